// ===== rtl/tbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types and constants of the two-button press classifier.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    // timer width and limits
    localparam int TIMER_BITS = 16;
    localparam int THR_BITS   = 16;
    localparam int CMP_BITS   = (TIMER_BITS > THR_BITS) ? TIMER_BITS : THR_BITS;

    // configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG     = CFG_IDX_BITS'(1);

    localparam logic [THR_BITS-1:0] DEBOUNCE_RESET = THR_BITS'(50);
    localparam logic [THR_BITS-1:0] LONG_RESET     = THR_BITS'(2000);

    // events per tick
    localparam int MAX_EVENTS = 3;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [THR_BITS-1:0]   t_thr;

    typedef enum logic [2:0] {
        EV_ANY_PRESS   = 3'd0,
        EV_LEFT_SHORT  = 3'd1,
        EV_LEFT_LONG   = 3'd2,
        EV_RIGHT_SHORT = 3'd3,
        EV_RIGHT_LONG  = 3'd4,
        EV_BOTH_LONG   = 3'd5
    } t_event;

    // saturating increment: stops at the threshold or at the counter maximum
    function automatic t_timer sat_inc(input t_timer c, input t_thr limit);
        logic [CMP_BITS-1:0] c_w;
        logic [CMP_BITS-1:0] l_w;
        c_w = CMP_BITS'(c);
        l_w = CMP_BITS'(limit);
        if ((c_w < l_w) && (c != {TIMER_BITS{1'b1}})) begin
            return c + t_timer'(1);
        end
        return c;
    endfunction

    // counter reached threshold
    function automatic logic reached(input t_timer c, input t_thr limit);
        return CMP_BITS'(c) >= CMP_BITS'(limit);
    endfunction

endpackage

// ===== rtl/two_button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// two_button_press_classifier
// Debounces two raw button levels and classifies any-press, short, long and
// both-long press events from the debounced levels.
// ----------------------------------------------------------------------------
// One input beat is one tick carrying both raw button levels. The tick is
// evaluated in the cycle it is accepted against the state registers, and the
// 0 to 3 events it causes are loaded into a result group register that is
// sent one beat per cycle while the output is not stalled, with last_event
// on the final one. A tick can be accepted every cycle while the result group
// is empty; a tick that causes events occupies the result group until its
// last beat is taken, and the next tick is taken in the same cycle the last
// beat of the group leaves. The configuration port is always ready; thresholds
// are the debounce and long-press tick counts, 0 meaning met at once.
module two_button_press_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_in_left_level,
    input  logic                              i_in_right_level,
    // event output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_out_event_code,
    output logic                              o_out_left_held,
    output logic                              o_out_right_held,
    output logic                              o_out_last_event,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbpc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [tbpc_pkg::THR_BITS-1:0]     i_cfg_data
);

    // configuration registers
    tbpc_pkg::t_thr r_debounce;
    tbpc_pkg::t_thr r_long;

    // per-button state
    logic [1:0]           r_raw,    n_raw;
    logic [1:0]           r_stable, n_stable;
    tbpc_pkg::t_timer     r_quiet [2];
    tbpc_pkg::t_timer     n_quiet [2];
    tbpc_pkg::t_timer     r_hold  [2];
    tbpc_pkg::t_timer     n_hold  [2];
    logic [1:0]           r_long_done, n_long_done;
    logic [1:0]           r_supp,      n_supp;

    // shared state
    logic                 r_any,       n_any;
    logic                 r_both_act,  n_both_act;
    tbpc_pkg::t_timer     r_both_cnt,  n_both_cnt;
    logic                 r_both_done, n_both_done;

    // result group
    logic                 r_busy;
    tbpc_pkg::t_event     r_code [tbpc_pkg::MAX_EVENTS];
    logic [1:0]           r_cnt;
    logic [1:0]           r_idx;
    logic                 r_left_p;
    logic                 r_right_p;

    // events of the current tick
    tbpc_pkg::t_event     e_code [tbpc_pkg::MAX_EVENTS];
    logic [1:0]           e_cnt;

    logic [1:0]           lvl;
    logic [1:0]           released;
    logic [1:0]           pressed_now;
    tbpc_pkg::t_timer     q_inc;
    tbpc_pkg::t_timer     bc_inc;
    logic                 out_take;
    logic                 out_last;
    logic                 in_accept;

    assign lvl = {i_in_right_level, i_in_left_level};

    // handshake
    assign out_take   = r_busy && !i_out_stall;
    assign out_last   = (r_idx == (r_cnt - 2'd1));
    assign o_in_stall = r_busy && !(out_take && out_last);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // tick evaluation
    always_comb begin
        n_raw       = r_raw;
        n_stable    = r_stable;
        n_long_done = r_long_done;
        n_supp      = r_supp;
        n_any       = r_any;
        n_both_act  = r_both_act;
        n_both_cnt  = r_both_cnt;
        n_both_done = r_both_done;
        released    = 2'b00;
        pressed_now = 2'b00;
        q_inc       = '0;
        bc_inc      = '0;
        e_cnt       = 2'd0;
        for (int k = 0; k < tbpc_pkg::MAX_EVENTS; k++) begin
            e_code[k] = tbpc_pkg::EV_ANY_PRESS;
        end

        // debounce and hold timing, independent per button
        for (int b = 0; b < 2; b++) begin
            n_quiet[b] = r_quiet[b];
            n_hold[b]  = r_hold[b];
            if (lvl[b] != r_raw[b]) begin
                n_raw[b]   = lvl[b];
                n_quiet[b] = '0;
            end else begin
                q_inc      = tbpc_pkg::sat_inc(r_quiet[b], r_debounce);
                n_quiet[b] = q_inc;
                if (tbpc_pkg::reached(q_inc, r_debounce) && (r_raw[b] != r_stable[b])) begin
                    n_stable[b] = r_raw[b];
                    if (r_raw[b]) begin
                        pressed_now[b] = 1'b1;
                        n_hold[b]      = '0;
                        n_long_done[b] = 1'b0;
                        n_supp[b]      = 1'b0;
                    end else begin
                        released[b] = 1'b1;
                    end
                end
            end
            if (n_stable[b] && !pressed_now[b]) begin
                n_hold[b] = tbpc_pkg::sat_inc(n_hold[b], r_long);
            end
        end

        // any press, once per episode
        if (n_stable != 2'b00) begin
            if (!r_any) begin
                e_code[e_cnt] = tbpc_pkg::EV_ANY_PRESS;
                e_cnt         = e_cnt + 2'd1;
                n_any         = 1'b1;
            end
        end else begin
            n_any = 1'b0;
        end

        if (n_stable == 2'b11) begin
            // both held: suppress singles, time the both-long event
            if (!r_both_act) begin
                n_both_act  = 1'b1;
                n_both_cnt  = '0;
                n_both_done = 1'b0;
                n_supp      = 2'b11;
            end else if (!r_both_done) begin
                bc_inc     = tbpc_pkg::sat_inc(r_both_cnt, r_long);
                n_both_cnt = bc_inc;
                if (tbpc_pkg::reached(bc_inc, r_long)) begin
                    n_both_done   = 1'b1;
                    n_long_done   = 2'b11;
                    e_code[e_cnt] = tbpc_pkg::EV_BOTH_LONG;
                    e_cnt         = e_cnt + 2'd1;
                end
            end
        end else begin
            n_both_act  = 1'b0;
            n_both_done = 1'b0;
            n_both_cnt  = '0;
            // single-button events, left first
            for (int b = 0; b < 2; b++) begin
                if (n_stable[b]) begin
                    if (!n_long_done[b] && !n_supp[b] &&
                        tbpc_pkg::reached(n_hold[b], r_long)) begin
                        n_long_done[b] = 1'b1;
                        if (e_cnt != 2'd3) begin
                            e_code[e_cnt] = (b == 0) ? tbpc_pkg::EV_LEFT_LONG
                                                     : tbpc_pkg::EV_RIGHT_LONG;
                            e_cnt = e_cnt + 2'd1;
                        end
                    end
                end else begin
                    if (released[b] && !n_long_done[b] && !n_supp[b]) begin
                        if (e_cnt != 2'd3) begin
                            e_code[e_cnt] = (b == 0) ? tbpc_pkg::EV_LEFT_SHORT
                                                     : tbpc_pkg::EV_RIGHT_SHORT;
                            e_cnt = e_cnt + 2'd1;
                        end
                    end
                    n_supp[b] = 1'b0;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= tbpc_pkg::DEBOUNCE_RESET;
            r_long     <= tbpc_pkg::LONG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tbpc_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                tbpc_pkg::CFG_LONG:     r_long     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw       <= 2'b00;
            r_stable    <= 2'b00;
            r_long_done <= 2'b00;
            r_supp      <= 2'b00;
            r_any       <= 1'b0;
            r_both_act  <= 1'b0;
            r_both_cnt  <= '0;
            r_both_done <= 1'b0;
            for (int b = 0; b < 2; b++) begin
                r_quiet[b] <= '0;
                r_hold[b]  <= '0;
            end
        end else if (in_accept) begin
            r_raw       <= n_raw;
            r_stable    <= n_stable;
            r_long_done <= n_long_done;
            r_supp      <= n_supp;
            r_any       <= n_any;
            r_both_act  <= n_both_act;
            r_both_cnt  <= n_both_cnt;
            r_both_done <= n_both_done;
            for (int b = 0; b < 2; b++) begin
                r_quiet[b] <= n_quiet[b];
                r_hold[b]  <= n_hold[b];
            end
        end
    end

    // result group control, a new group replaces the one whose last beat leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_cnt  <= 2'd0;
        end else if (in_accept && (e_cnt != 2'd0)) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
            r_cnt  <= e_cnt;
        end else if (out_take) begin
            if (out_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // result group payload
    always_ff @(posedge i_clk) begin
        if (in_accept && (e_cnt != 2'd0)) begin
            for (int k = 0; k < tbpc_pkg::MAX_EVENTS; k++) begin
                r_code[k] <= e_code[k];
            end
            r_left_p  <= n_stable[0];
            r_right_p <= n_stable[1];
        end
    end

    // output beat
    always_comb begin
        case (r_idx)
            2'd0:    o_out_event_code = r_code[0];
            2'd1:    o_out_event_code = r_code[1];
            default: o_out_event_code = r_code[2];
        endcase
    end

    assign o_out_valid       = r_busy;
    assign o_out_left_held   = r_left_p;
    assign o_out_right_held  = r_right_p;
    assign o_out_last_event  = out_last;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-button press classifier: drives tick beats
// of raw button levels under random idling, predicts the event beats of each
// tick and checks them in order, across a sweep of threshold settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDX_W = tbpc_pkg::CFG_IDX_BITS;
    localparam int DAT_W = tbpc_pkg::THR_BITS;

    // register indexes the block does not decode
    localparam logic [IDX_W-1:0] CFG_SPARE_A = IDX_W'(2);
    localparam logic [IDX_W-1:0] CFG_SPARE_B = IDX_W'(3);

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES   = 9;

    // threshold sweep for the random part, the last setting is drawn at random
    localparam int DEB_TAB [RAND_PHASES] = '{0, 1, 2, 4, 0, 3, 65535, 1, 0};
    localparam int LNG_TAB [RAND_PHASES] = '{0, 3, 8, 16, 5, 0, 65535, 65535, 2};
    localparam int CNT_TAB [RAND_PHASES] = '{50, 60, 70, 60, 40, 40, 20, 40, 30};

    // directed press patterns: bit 1 left, bit 0 right
    localparam int DIR_STEPS = 10;
    localparam logic [1:0] DIR_LVL [DIR_STEPS] =
        '{2'b10, 2'b00, 2'b01, 2'b00, 2'b10, 2'b00, 2'b01, 2'b00, 2'b11, 2'b00};
    localparam int DIR_REP [DIR_STEPS] = '{2, 2, 2, 2, 4, 2, 4, 2, 4, 2};

    typedef struct packed {
        tbpc_pkg::t_event code;
        logic             left;
        logic             right;
        logic             last;
    } t_press_event;

    // tracks debounce and press state, queues the event beats each tick causes
    class press_scoreboard;
        tbpc_pkg::t_thr   debounce_thr;
        tbpc_pkg::t_thr   long_thr;
        bit               raw_q[2];
        bit               level[2];
        bit               long_hit[2];
        bit               muted[2];
        tbpc_pkg::t_timer quiet[2];
        tbpc_pkg::t_timer hold[2];
        bit               any_seen;
        bit               pair_on;
        bit               pair_hit;
        tbpc_pkg::t_timer pair_hold;
        t_press_event     event_q[$];
        int               errors;
        int               ticks;
        int               beats;

        function new();
            debounce_thr = tbpc_pkg::DEBOUNCE_RESET;
            long_thr     = tbpc_pkg::LONG_RESET;
            errors       = 0;
            ticks        = 0;
            beats        = 0;
        endfunction

        // saturating count up to the threshold or the counter maximum
        function tbpc_pkg::t_timer bump(tbpc_pkg::t_timer c, tbpc_pkg::t_thr lim);
            if (c < lim && c != {tbpc_pkg::TIMER_BITS{1'b1}}) begin
                return c + tbpc_pkg::t_timer'(1);
            end
            return c;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, tbpc_pkg::t_thr data);
            if (idx == tbpc_pkg::CFG_DEBOUNCE) begin
                debounce_thr = data;
            end else if (idx == tbpc_pkg::CFG_LONG) begin
                long_thr = data;
            end
        endfunction

        function void add_event(tbpc_pkg::t_event code);
            t_press_event ev;
            ev.code  = code;
            ev.left  = level[0];
            ev.right = level[1];
            ev.last  = 1'b0;
            event_q.push_back(ev);
        endfunction

        function void note_tick(bit lvl_l, bit lvl_r);
            bit rel[2];
            bit fresh;
            bit raw;
            int base_n;
            base_n = event_q.size();
            rel[0] = 1'b0;
            rel[1] = 1'b0;
            ticks++;
            // debounce each button and track hold time
            for (int b = 0; b < 2; b++) begin
                raw   = (b == 0) ? lvl_l : lvl_r;
                fresh = 1'b0;
                if (raw != raw_q[b]) begin
                    raw_q[b] = raw;
                    quiet[b] = '0;
                end else begin
                    quiet[b] = bump(quiet[b], debounce_thr);
                    if (quiet[b] >= debounce_thr && raw_q[b] != level[b]) begin
                        level[b] = raw_q[b];
                        if (level[b]) begin
                            fresh       = 1'b1;
                            hold[b]     = '0;
                            long_hit[b] = 1'b0;
                            muted[b]    = 1'b0;
                        end else begin
                            rel[b] = 1'b1;
                        end
                    end
                end
                if (level[b] && !fresh) begin
                    hold[b] = bump(hold[b], long_thr);
                end
            end
            // any press, once per episode
            if (level[0] || level[1]) begin
                if (!any_seen) begin
                    add_event(tbpc_pkg::EV_ANY_PRESS);
                    any_seen = 1'b1;
                end
            end else begin
                any_seen = 1'b0;
            end
            // both held: suppress singles, time the both-long
            if (level[0] && level[1]) begin
                if (!pair_on) begin
                    pair_on   = 1'b1;
                    pair_hold = '0;
                    pair_hit  = 1'b0;
                    muted[0]  = 1'b1;
                    muted[1]  = 1'b1;
                end else if (!pair_hit) begin
                    pair_hold = bump(pair_hold, long_thr);
                    if (pair_hold >= long_thr) begin
                        pair_hit    = 1'b1;
                        long_hit[0] = 1'b1;
                        long_hit[1] = 1'b1;
                        add_event(tbpc_pkg::EV_BOTH_LONG);
                    end
                end
            end else begin
                pair_on   = 1'b0;
                pair_hit  = 1'b0;
                pair_hold = '0;
                for (int b = 0; b < 2; b++) begin
                    if (level[b]) begin
                        if (!long_hit[b] && !muted[b] && hold[b] >= long_thr) begin
                            long_hit[b] = 1'b1;
                            if (b == 0) begin
                                add_event(tbpc_pkg::EV_LEFT_LONG);
                            end else begin
                                add_event(tbpc_pkg::EV_RIGHT_LONG);
                            end
                        end
                    end else begin
                        if (rel[b] && !long_hit[b] && !muted[b]) begin
                            if (b == 0) begin
                                add_event(tbpc_pkg::EV_LEFT_SHORT);
                            end else begin
                                add_event(tbpc_pkg::EV_RIGHT_SHORT);
                            end
                        end
                        muted[b] = 1'b0;
                    end
                end
            end
            if (event_q.size() > base_n) begin
                event_q[event_q.size()-1].last = 1'b1;
            end
        endfunction

        function void check_event(logic [2:0] code, logic lp, logic rp, logic last);
            t_press_event want;
            beats++;
            if (event_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected event beat code=%0d left=%0d right=%0d last=%0d",
                         $time, code, lp, rp, last);
                return;
            end
            want = event_q.pop_front();
            if (code !== want.code) begin
                errors++;
                $display("%0t: event_code expected %0d, got %0d", $time, want.code, code);
            end
            if (lp !== want.left) begin
                errors++;
                $display("%0t: left held expected %0d, got %0d", $time, want.left, lp);
            end
            if (rp !== want.right) begin
                errors++;
                $display("%0t: right held expected %0d, got %0d", $time, want.right, rp);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last_event expected %0d, got %0d", $time, want.last, last);
            end
        endfunction

        function int pending();
            return event_q.size();
        endfunction
    endclass

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic               i_in_left_level  = 1'b0;
    logic               i_in_right_level = 1'b0;
    logic               i_out_stall      = 1'b0;
    logic               i_cfg_valid      = 1'b0;
    logic [IDX_W-1:0]   i_cfg_index      = '0;
    logic [DAT_W-1:0]   i_cfg_data       = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [2:0]         o_out_event_code;
    logic               o_out_left_held;
    logic               o_out_right_held;
    logic               o_out_last_event;
    logic               o_cfg_ready;

    press_scoreboard sb = new();
    bit              calm = 1'b0;
    int unsigned     cycles = 0;

    two_button_press_classifier DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_left_level     (i_in_left_level),
        .i_in_right_level    (i_in_right_level),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_event_code    (o_out_event_code),
        .o_out_left_held     (o_out_left_held),
        .o_out_right_held    (o_out_right_held),
        .o_out_last_event    (o_out_last_event),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // check each accepted event beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_event(o_out_event_code, o_out_left_held, o_out_right_held,
                           o_out_last_event);
        end
    end

    // event sink with random stall before each beat
    initial begin
        int hold_n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold_n = calm ? 0 : $urandom_range(0, 4);
            if (hold_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_reg(idx, data);
    endtask

    task automatic send_tick(input logic lvl_l, input logic lvl_r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_in_left_level  <= lvl_l;
        i_in_right_level <= lvl_r;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_tick(lvl_l, lvl_r);
    endtask

    // stop sending until every expected beat is in, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // held level pairs of random length with the odd bounce mixed in
    task automatic run_phase(input int count, input int deb, input int lng);
        int       sent;
        int       span;
        int       len;
        bit [1:0] aim;
        bit [1:0] lv;
        sent = 0;
        while (sent < count) begin
            calm = ($urandom_range(0, 4) == 0);
            aim  = 2'($urandom_range(0, 3));
            span = deb + lng + 3;
            if (span > 40) begin
                span = 40;
            end
            len = $urandom_range(1, span);
            for (int i = 0; i < len && sent < count; i++) begin
                lv = aim;
                if ($urandom_range(0, 11) == 0) begin
                    lv = 2'($urandom_range(0, 3));
                end
                send_tick(lv[1], lv[0]);
                sent++;
            end
            if ($urandom_range(0, 19) == 0) begin
                settle();
            end
        end
    endtask

    // main sequence
    initial begin
        int deb;
        int lng;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed presses: short, long and both-long on tight thresholds
        write_reg(tbpc_pkg::CFG_DEBOUNCE, DAT_W'(1));
        write_reg(tbpc_pkg::CFG_LONG, DAT_W'(2));
        i_cfg_valid <= 1'b0;
        for (int s = 0; s < DIR_STEPS; s++) begin
            for (int r = 0; r < DIR_REP[s]; r++) begin
                send_tick(DIR_LVL[s][1], DIR_LVL[s][0]);
            end
        end
        settle();

        // random presses across the threshold sweep
        for (int p = 0; p < RAND_PHASES; p++) begin
            deb = DEB_TAB[p];
            lng = LNG_TAB[p];
            if (p == RAND_PHASES - 1) begin
                deb = $urandom_range(0, 3);
                lng = $urandom_range(0, 10);
            end
            if (p == 2) begin
                write_reg(CFG_SPARE_A, DAT_W'($urandom));
            end
            write_reg(tbpc_pkg::CFG_DEBOUNCE, DAT_W'(deb));
            write_reg(tbpc_pkg::CFG_LONG, DAT_W'(lng));
            if (p == 5) begin
                write_reg(CFG_SPARE_B, {DAT_W{1'b1}});
            end
            i_cfg_valid <= 1'b0;
            run_phase(CNT_TAB[p], deb, lng);
            settle();
        end
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d ticks over %0d threshold settings, %0d event beats checked",
                 sb.ticks, RAND_PHASES + 1, sb.beats);
        $display("thresholds swept from 0 to full scale, unused register indexes written too");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tbpc_pkg.sv
rtl/two_button_press_classifier.sv
test/testbench.sv
